### src/batw_pkg.sv
`timescale 1ns / 1ps

package batw_pkg;

  typedef enum logic [2:0] {
    CMD_ENABLE  = 3'd0,
    CMD_DISABLE = 3'd1,
    CMD_BUMPER  = 3'd2,
    CMD_CLIFF   = 3'd3,
    CMD_WHEEL   = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LINEAR_VEL  = 2'd0,
    REG_ANGULAR_VEL = 2'd1,
    REG_HALF_TURN   = 2'd2
  } reg_idx_t;

  localparam logic [1:0] COL_BLACK  = 2'd0;
  localparam logic [1:0] COL_ORANGE = 2'd1;
  localparam logic [1:0] COL_RED    = 2'd2;

  localparam int unsigned LAMP_BUMP  = 0;
  localparam int unsigned LAMP_CLIFF = 1;
  localparam int unsigned LAMP_WHEEL = 2;

  localparam logic [15:0] ELAPSED_MAX = 16'hffff;

  typedef struct packed {
    logic [1:0]  lamp2_color;
    logic [1:0]  lamp1_color;
    logic [15:0] angular_cmd;
    logic [15:0] linear_cmd;
    logic        lamp2_valid;
    logic        lamp1_valid;
    logic        vel_valid;
  } result_t;

endpackage

### src/bump_and_turn_walker.sv
`timescale 1ns / 1ps

// path from input accept to result valid: input register, then result register
// throughput: one request per cycle, no bubbles while the result side keeps up
// the single 16x20 turn length multiply sits between the two registers
// reset (rst_n low, synchronous): pipeline empty, controller enabled, all flags clear,
// speeds 500 mm/s and 100 mrad/s, half turn 5027 in q16.4 ticks
module bump_and_turn_walker
  import batw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] event_side, [2] event_active, [18:3] random_sample, rest zero
  input  logic [23:0] in_tdata,
  // [2:0] command
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] linear_cmd, [31:16] angular_cmd, [33:32] lamp1_color,
  // [35:34] lamp2_color, rest zero
  output logic [39:0] out_tdata,
  // [0] vel_valid, [1] lamp1_valid, [2] lamp2_valid
  output logic [2:0]  out_tuser
);

  logic [15:0] lin_vel_r;
  logic [15:0] ang_vel_r;
  logic [19:0] half_turn_r;

  logic        in_vld_r;
  logic [2:0]  in_cmd_r;
  logic [1:0]  in_side_r;
  logic        in_act_r;
  logic [15:0] in_rnd_r;

  logic        out_vld_r;
  result_t     res_r, res_nxt;

  logic        on_r, on_nxt;
  logic        pending_r, pending_nxt;
  logic        halted_r, halted_nxt;
  logic [2:0]  bump_r, bump_nxt;
  logic [2:0]  cliff_r, cliff_nxt;
  logic [1:0]  wheel_r, wheel_nxt;
  logic [2:0]  lamp_r, lamp_nxt;
  logic        turning_r, turning_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [19:0] length_r, length_nxt;

  logic        proc;
  logic        adv;
  logic [15:0] mag;
  logic [35:0] prod;
  logic [15:0] ang_neg;
  logic [2:0]  side_bit3;
  logic [1:0]  side_bit2;
  logic        side3_ok;
  logic        side2_ok;

  assign adv       = !out_vld_r || out_tready;
  assign proc      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_vel_r   <= 16'd500;
      ang_vel_r   <= 16'd100;
      half_turn_r <= 20'd5027;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LINEAR_VEL:  lin_vel_r   <= cfg_wdata[15:0];
        REG_ANGULAR_VEL: ang_vel_r   <= cfg_wdata[15:0];
        REG_HALF_TURN:   half_turn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= in_tuser;
      in_side_r <= in_tdata[1:0];
      in_act_r  <= in_tdata[2];
      in_rnd_r  <= in_tdata[18:3];
    end
  end

  assign side3_ok  = (in_side_r != 2'd3);
  assign side2_ok  = !in_side_r[1];
  assign side_bit3 = 3'b001 << in_side_r;
  assign side_bit2 = 2'b01 << in_side_r[0];

  // |r| in q1.15, -1.0 maps to magnitude 32768
  assign mag     = in_rnd_r[15] ? (~in_rnd_r + 16'd1) : in_rnd_r;
  assign prod    = {20'd0, mag} * {16'd0, half_turn_r};
  assign ang_neg = (ang_vel_r == 16'h8000) ? 16'h7fff : (~ang_vel_r + 16'd1);

  always_comb begin
    on_nxt      = on_r;
    pending_nxt = pending_r;
    halted_nxt  = halted_r;
    bump_nxt    = bump_r;
    cliff_nxt   = cliff_r;
    wheel_nxt   = wheel_r;
    lamp_nxt    = lamp_r;
    turning_nxt = turning_r;
    neg_nxt     = neg_r;
    elapsed_nxt = elapsed_r;
    length_nxt  = length_r;
    res_nxt     = '0;

    case (in_cmd_r)
      CMD_ENABLE:  on_nxt = 1'b1;
      CMD_DISABLE: on_nxt = 1'b0;
      CMD_BUMPER: begin
        if (on_r) begin
          if (side3_ok) begin
            if (in_act_r) begin
              if ((bump_r & side_bit3) == 3'd0) pending_nxt = 1'b1;
              bump_nxt = bump_r | side_bit3;
            end else begin
              bump_nxt = bump_r & ~side_bit3;
            end
          end
          if (!lamp_r[LAMP_BUMP] && bump_nxt != 3'd0) begin
            res_nxt.lamp1_valid = 1'b1;
            res_nxt.lamp1_color = COL_ORANGE;
            lamp_nxt[LAMP_BUMP] = 1'b1;
          end else if (lamp_r[LAMP_BUMP] && bump_nxt == 3'd0) begin
            res_nxt.lamp1_valid = 1'b1;
            res_nxt.lamp1_color = COL_BLACK;
            lamp_nxt[LAMP_BUMP] = 1'b0;
          end
        end
      end
      CMD_CLIFF: begin
        if (side3_ok) begin
          if (in_act_r) begin
            if ((cliff_r & side_bit3) == 3'd0) pending_nxt = 1'b1;
            cliff_nxt = cliff_r | side_bit3;
          end else begin
            cliff_nxt = cliff_r & ~side_bit3;
          end
        end
        if (!lamp_r[LAMP_CLIFF] && cliff_nxt != 3'd0) begin
          res_nxt.lamp2_valid = 1'b1;
          res_nxt.lamp2_color = COL_ORANGE;
          lamp_nxt[LAMP_CLIFF] = 1'b1;
        end else if (lamp_r[LAMP_CLIFF] && cliff_nxt == 3'd0) begin
          res_nxt.lamp2_valid = 1'b1;
          res_nxt.lamp2_color = COL_BLACK;
          lamp_nxt[LAMP_CLIFF] = 1'b0;
        end
      end
      CMD_WHEEL: begin
        if (side2_ok) begin
          if (in_act_r) wheel_nxt = wheel_r | side_bit2;
          else          wheel_nxt = wheel_r & ~side_bit2;
        end
        if (!lamp_r[LAMP_WHEEL] && wheel_nxt != 2'd0) begin
          res_nxt.lamp1_valid = 1'b1;
          res_nxt.lamp1_color = COL_RED;
          res_nxt.lamp2_valid = 1'b1;
          res_nxt.lamp2_color = COL_RED;
          halted_nxt = 1'b1;
          lamp_nxt[LAMP_WHEEL] = 1'b1;
        end else if (lamp_r[LAMP_WHEEL] && wheel_nxt == 2'd0) begin
          res_nxt.lamp1_valid = 1'b1;
          res_nxt.lamp1_color = COL_BLACK;
          res_nxt.lamp2_valid = 1'b1;
          res_nxt.lamp2_color = COL_BLACK;
          halted_nxt = 1'b0;
          lamp_nxt[LAMP_WHEEL] = 1'b0;
        end
      end
      CMD_TICK: begin
        if (turning_r && elapsed_r != ELAPSED_MAX) elapsed_nxt = elapsed_r + 16'd1;
        if (on_r) begin
          if (halted_r) begin
            res_nxt.vel_valid = 1'b1;
          end else begin
            if (pending_r) begin
              pending_nxt = 1'b0;
              neg_nxt     = in_rnd_r[15];
              length_nxt  = prod[34:15];
              elapsed_nxt = 16'd0;
              turning_nxt = 1'b1;
            end
            if (turning_nxt) begin
              if (elapsed_nxt != ELAPSED_MAX && {elapsed_nxt, 4'd0} < length_nxt) begin
                res_nxt.vel_valid   = 1'b1;
                res_nxt.angular_cmd = neg_nxt ? ang_neg : ang_vel_r;
              end else begin
                turning_nxt = 1'b0;
              end
            end else begin
              res_nxt.vel_valid  = 1'b1;
              res_nxt.linear_cmd = lin_vel_r;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r      <= 1'b1;
      pending_r <= 1'b0;
      halted_r  <= 1'b0;
      bump_r    <= 3'd0;
      cliff_r   <= 3'd0;
      wheel_r   <= 2'd0;
      lamp_r    <= 3'd0;
      turning_r <= 1'b0;
      neg_r     <= 1'b0;
      elapsed_r <= 16'd0;
      length_r  <= 20'd0;
    end else if (proc) begin
      on_r      <= on_nxt;
      pending_r <= pending_nxt;
      halted_r  <= halted_nxt;
      bump_r    <= bump_nxt;
      cliff_r   <= cliff_nxt;
      wheel_r   <= wheel_nxt;
      lamp_r    <= lamp_nxt;
      turning_r <= turning_nxt;
      neg_r     <= neg_nxt;
      elapsed_r <= elapsed_nxt;
      length_r  <= length_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) res_r <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = {res_r.lamp2_valid, res_r.lamp1_valid, res_r.vel_valid};
  assign out_tdata  = {4'd0, res_r.lamp2_color, res_r.lamp1_color,
                       res_r.angular_cmd, res_r.linear_cmd};

  // lamp flags track the sensor flags they summarize
  a_bump_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    lamp_r[LAMP_BUMP] == (bump_r != 3'd0))
    else $error("bumper lamp flag out of step with bumper flags");

  a_cliff_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    lamp_r[LAMP_CLIFF] == (cliff_r != 3'd0))
    else $error("cliff lamp flag out of step with cliff flags");

  a_wheel_halt: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r == lamp_r[LAMP_WHEEL] && halted_r == (wheel_r != 2'd0))
    else $error("halt state out of step with wheel drop flags");

  a_tick_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_cmd_r == CMD_TICK && on_r && !halted_r) |=> !pending_r)
    else $error("pending turn survived an enabled tick");

  a_one_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.linear_cmd != 16'd0) |-> (res_r.angular_cmd == 16'd0))
    else $error("linear and angular command both nonzero");

endmodule
